@@ rtl/core/state_filter_with_undo_stack_unit_defines.svh @@
// ----------------------------------------------------------------------------
// State filter with undo stack: assertion macros
// Shared macros for the concurrent assertions of the state filter block.
// ----------------------------------------------------------------------------
`ifndef STATE_FILTER_WITH_UNDO_STACK_UNIT_DEFINES_SVH
`define STATE_FILTER_WITH_UNDO_STACK_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFUS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFUS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/sfus_pkg.sv @@
// ----------------------------------------------------------------------------
// State filter with undo stack: package
// Sizes, opcode and status codes, and the command types between the units.
// ----------------------------------------------------------------------------
package sfus_pkg;

   localparam int NUM_STATES     = 256;
   localparam int STACK_DEPTH    = 8;
   localparam int LAYER_CAPACITY = 32;

   localparam int OP_W     = 2;
   localparam int IDX_W    = 8;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 3;

   localparam int SH_W    = $clog2(NUM_STATES);
   localparam int LYR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SLOT_W  = (LAYER_CAPACITY > 1) ? $clog2(LAYER_CAPACITY) : 1;
   localparam int FILL_W  = $clog2(LAYER_CAPACITY + 1);
   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int LOG_DEPTH = 1 << (LYR_W + SLOT_W);

   // Opcodes of a request beat.
   localparam logic [OP_W-1:0] OP_SET   = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
   localparam logic [OP_W-1:0] OP_POP   = 2'd2;
   localparam logic [OP_W-1:0] OP_FORCE = 2'd3;

   // Status codes of a response beat.
   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd1;
   localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NO_LAYER  = 3'd3;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd4;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
   } log_entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [SH_W-1:0]  rd_addr;
      logic             wr_en;
      logic [SH_W-1:0]  wr_addr;
      logic [VAL_W-1:0] wr_data;
   } shadow_cmd_type;

   typedef struct packed {
      logic              rd_en;
      logic [LYR_W-1:0]  rd_layer;
      logic [SLOT_W-1:0] rd_slot;
      logic              wr_en;
      logic [LYR_W-1:0]  wr_layer;
      logic [SLOT_W-1:0] wr_slot;
      log_entry_type     wr_entry;
   } journal_cmd_type;

endpackage

@@ rtl/core/sfus_shadow_table.sv @@
// ----------------------------------------------------------------------------
// State filter with undo stack: shadow table
// Single-port-write, registered-read memory of current state values, zeroed
// by a sweep after reset.
// ----------------------------------------------------------------------------
module sfus_shadow_table (
   input  logic                         clock,
   input  logic                         reset,
   input  sfus_pkg::shadow_cmd_type     cmd,
   output logic [sfus_pkg::VAL_W-1:0]   rd_data,
   output logic                         clr_busy
);
   import sfus_pkg::*;

   logic [VAL_W-1:0] mem [NUM_STATES];
   logic [VAL_W-1:0] rd_data_ff;
   logic             clr_busy_ff;
   logic [SH_W-1:0]  clr_addr_ff;

   logic             wr_en;
   logic [SH_W-1:0]  wr_addr;
   logic [VAL_W-1:0] wr_data;

   // The clearing sweep owns the write port until every entry is zero.
   always_comb begin
      wr_en   = clr_busy_ff | cmd.wr_en;
      wr_addr = clr_busy_ff ? clr_addr_ff : cmd.wr_addr;
      wr_data = clr_busy_ff ? '0 : cmd.wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == SH_W'(NUM_STATES - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

@@ rtl/core/sfus_undo_journal.sv @@
// ----------------------------------------------------------------------------
// State filter with undo stack: undo journal
// Memory of logged (index, old value) pairs, one row of slots per layer.
// ----------------------------------------------------------------------------
module sfus_undo_journal (
   input  logic                        clock,
   input  sfus_pkg::journal_cmd_type   cmd,
   output sfus_pkg::log_entry_type     rd_entry
);
   import sfus_pkg::*;

   log_entry_type mem [LOG_DEPTH];
   log_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[{cmd.wr_layer, cmd.wr_slot}] <= cmd.wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_entry_ff <= mem[{cmd.rd_layer, cmd.rd_slot}];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

@@ rtl/core/sfus_sequencer.sv @@
// ----------------------------------------------------------------------------
// State filter with undo stack: sequencer
// Decodes request beats, drives both memories, keeps the layer stack and
// holds the response register.
// ----------------------------------------------------------------------------
module sfus_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sfus_pkg::OP_W-1:0]       req_opcode,
   input  logic [sfus_pkg::IDX_W-1:0]      req_state_index,
   input  logic [sfus_pkg::VAL_W-1:0]      req_new_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sfus_pkg::STATUS_W-1:0]   rsp_status,
   output logic [sfus_pkg::IDX_W-1:0]      rsp_write_index,
   output logic [sfus_pkg::VAL_W-1:0]      rsp_write_value,
   output logic                            rsp_last,
   output sfus_pkg::shadow_cmd_type        sh_cmd,
   input  logic [sfus_pkg::VAL_W-1:0]      sh_rd_data,
   input  logic                            clr_busy,
   output sfus_pkg::journal_cmd_type       jr_cmd,
   input  sfus_pkg::log_entry_type         jr_rd_entry
);
   import sfus_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic [CNT_W-1:0]    open_cnt_ff, open_cnt_in;
   logic [FILL_W-1:0]   fill_ff [STACK_DEPTH];
   logic [FILL_W-1:0]   fill_in [STACK_DEPTH];
   logic [FILL_W-1:0]   cnt_ff, cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                out_free;
   logic                idx_ok;
   logic [LYR_W-1:0]    top_lyr;
   logic [FILL_W-1:0]   fill_top;
   logic [FILL_W-1:0]   cnt_dec;

   assign req_stall = (state_ff != ST_IDLE) || clr_busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_ok    = (32'(idx_ff) < 32'(NUM_STATES));
   assign top_lyr   = LYR_W'(open_cnt_ff - 1'b1);
   assign fill_top  = fill_ff[top_lyr];
   assign cnt_dec   = cnt_ff - 1'b1;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      open_cnt_in   = open_cnt_ff;
      fill_in       = fill_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      sh_cmd        = '0;
      jr_cmd        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in          = req_opcode;
               idx_in         = req_state_index;
               val_in         = req_new_value;
               sh_cmd.rd_en   = 1'b1;
               sh_cmd.rd_addr = SH_W'(req_state_index);
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
               unique case (op_ff)
                  OP_SET: begin
                     if (idx_ok && (sh_rd_data != val_ff)) begin
                        rsp_valid_in = 1'b1;
                        rsp_last_in  = 1'b1;
                        rsp_index_in = '0;
                        rsp_value_in = '0;
                        if (open_cnt_ff == '0) begin
                           rsp_status_in = STS_NO_LAYER;
                        end else if (fill_top == FILL_W'(LAYER_CAPACITY)) begin
                           rsp_status_in = STS_FULL;
                        end else begin
                           jr_cmd.wr_en          = 1'b1;
                           jr_cmd.wr_layer       = top_lyr;
                           jr_cmd.wr_slot        = SLOT_W'(fill_top);
                           jr_cmd.wr_entry.index = idx_ff;
                           jr_cmd.wr_entry.value = sh_rd_data;
                           fill_in[top_lyr]      = fill_top + 1'b1;
                           sh_cmd.wr_en          = 1'b1;
                           sh_cmd.wr_addr        = SH_W'(idx_ff);
                           sh_cmd.wr_data        = val_ff;
                           rsp_status_in         = STS_OK;
                           rsp_index_in          = idx_ff;
                           rsp_value_in          = val_ff;
                        end
                     end
                  end
                  OP_PUSH: begin
                     if (open_cnt_ff == CNT_W'(STACK_DEPTH)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = STS_OVERFLOW;
                        rsp_index_in  = '0;
                        rsp_value_in  = '0;
                     end else begin
                        open_cnt_in                  = open_cnt_ff + 1'b1;
                        fill_in[LYR_W'(open_cnt_ff)] = '0;
                     end
                  end
                  OP_POP: begin
                     if (open_cnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = STS_UNDERFLOW;
                        rsp_index_in  = '0;
                        rsp_value_in  = '0;
                     end else if (fill_top == '0) begin
                        open_cnt_in = open_cnt_ff - 1'b1;
                     end else begin
                        // Fetch the newest entry of the layer first.
                        cnt_in          = fill_top;
                        jr_cmd.rd_en    = 1'b1;
                        jr_cmd.rd_layer = top_lyr;
                        jr_cmd.rd_slot  = SLOT_W'(fill_top - 1'b1);
                        state_in        = ST_POP;
                     end
                  end
                  OP_FORCE: begin
                     if (idx_ok) begin
                        sh_cmd.wr_en   = 1'b1;
                        sh_cmd.wr_addr = SH_W'(idx_ff);
                        sh_cmd.wr_data = val_ff;
                        rsp_valid_in   = 1'b1;
                        rsp_last_in    = 1'b1;
                        rsp_status_in  = STS_OK;
                        rsp_index_in   = idx_ff;
                        rsp_value_in   = val_ff;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_POP: begin
            if (out_free) begin
               // Logged indexes were checked when logged, so they always fit.
               sh_cmd.wr_en   = 1'b1;
               sh_cmd.wr_addr = SH_W'(jr_rd_entry.index);
               sh_cmd.wr_data = jr_rd_entry.value;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STS_OK;
               rsp_index_in   = jr_rd_entry.index;
               rsp_value_in   = jr_rd_entry.value;
               rsp_last_in    = (cnt_dec == '0);
               cnt_in         = cnt_dec;
               if (cnt_dec == '0) begin
                  fill_in[top_lyr] = '0;
                  open_cnt_in      = open_cnt_ff - 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  jr_cmd.rd_en    = 1'b1;
                  jr_cmd.rd_layer = top_lyr;
                  jr_cmd.rd_slot  = SLOT_W'(cnt_dec - 1'b1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_cnt_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STACK_DEPTH; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         open_cnt_ff  <= open_cnt_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_write_index = rsp_index_ff;
   assign rsp_write_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ rtl/core/state_filter_with_undo_stack_unit.sv @@
// ----------------------------------------------------------------------------
// State filter with undo stack
// Redundant state filter with a layered undo journal, top level.
// ----------------------------------------------------------------------------
// The block keeps a shadow copy of every state entry and forwards only writes
// that really change it. A filtered set that changes an entry logs the old
// value in the open undo layer; a push opens a layer and a pop replays that
// layer's logged writes newest first, one response beat each, then closes it.
// A force write is forwarded and stored without filtering or logging. Errors
// (overflow, underflow, no open layer, full layer) come back as a single
// response beat with a zero index and value and change nothing. A set,
// force, push or pop of an empty layer passes through the request beat and
// the registered shadow table read; a pop of a layer with logged entries then
// gives one response beat per cycle out of the journal memory, while rsp_stall
// does not hold a waiting beat. After reset the shadow table is zeroed by a
// sweep over all NUM_STATES entries (256), during which req_stall stays high.
// ----------------------------------------------------------------------------
`include "state_filter_with_undo_stack_unit_defines.svh"

module state_filter_with_undo_stack_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sfus_pkg::OP_W-1:0]       req_opcode,
   input  logic [sfus_pkg::IDX_W-1:0]      req_state_index,
   input  logic [sfus_pkg::VAL_W-1:0]      req_new_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sfus_pkg::STATUS_W-1:0]   rsp_status,
   output logic [sfus_pkg::IDX_W-1:0]      rsp_write_index,
   output logic [sfus_pkg::VAL_W-1:0]      rsp_write_value,
   output logic                            rsp_last
);
   import sfus_pkg::*;

   // Command and read paths between the sequencer and the two memories.
   shadow_cmd_type   sh_cmd;
   logic [VAL_W-1:0] sh_rd_data;
   logic             clr_busy;
   journal_cmd_type  jr_cmd;
   log_entry_type    jr_rd_entry;

   // The shadow table holds the current value of every state entry.
   sfus_shadow_table u_shadow (
      .clock    (clock),
      .reset    (reset),
      .cmd      (sh_cmd),
      .rd_data  (sh_rd_data),
      .clr_busy (clr_busy)
   );

   // The journal holds one row of logged writes per stack layer.
   sfus_undo_journal u_journal (
      .clock    (clock),
      .cmd      (jr_cmd),
      .rd_entry (jr_rd_entry)
   );

   // The sequencer decodes each request beat and walks a layer on a pop.
   sfus_sequencer u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_state_index (req_state_index),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_write_index (rsp_write_index),
      .rsp_write_value (rsp_write_value),
      .rsp_last        (rsp_last),
      .sh_cmd          (sh_cmd),
      .sh_rd_data      (sh_rd_data),
      .clr_busy        (clr_busy),
      .jr_cmd          (jr_cmd),
      .jr_rd_entry     (jr_rd_entry)
   );

   // No request is taken while the clearing sweep still owns the table.
   `SFUS_ASSERT_SAME(a_no_req_while_clearing, clock, reset, clr_busy, req_stall, "request taken during clear")

   // An error beat is always the only beat of its item and carries no write.
   `SFUS_ASSERT_SAME(a_error_beat_shape, clock, reset, rsp_valid && (rsp_status != STS_OK), rsp_last && (rsp_write_index == '0) && (rsp_write_value == '0), "malformed error beat")

   // Every logged entry belongs to a write of the shadow table in that cycle.
   `SFUS_ASSERT_SAME(a_log_with_write, clock, reset, jr_cmd.wr_en, sh_cmd.wr_en && (sh_cmd.wr_data != jr_cmd.wr_entry.value), "journal write without change")

   // The cycle after a request beat is taken belongs to its table read.
   `SFUS_ASSERT_NEXT(a_stall_after_accept, clock, reset, req_valid && !req_stall, req_stall, "back-to-back request beats")

endmodule

@@ sim/tb_state_filter_with_undo_stack_unit.sv @@
// ----------------------------------------------------------------------------
// State filter with undo stack: testbench
// Drives set, push, pop and force beats into the filter, predicts every write
// beat it must forward, and compares the response channel beat by beat.
// ----------------------------------------------------------------------------
module tb_state_filter_with_undo_stack_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import sfus_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 7;
   // Total request beats: the directed opening plus the random body.
   localparam int TOTAL_ITEMS  = 360;
   localparam int HALF_ITEMS   = TOTAL_ITEMS / 2;
   // This is many times the length of the slowest legal run.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;
   // Meant to cover the replay of a full layer and its stalls.
   localparam int SETTLE_CYCLES = 96;
   localparam int IDLE_PERCENT  = 28;
   // Inside this window of the cycle counter neither side idles.
   localparam int CALM_FROM = 700;
   localparam int CALM_TO   = 1500;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
   } state_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index;
      logic [VAL_W-1:0]    value;
      logic                last;
   } write_beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [IDX_W-1:0]    req_state_index = '0;
   logic [VAL_W-1:0]    req_new_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_write_index;
   logic [VAL_W-1:0]    rsp_write_value;
   logic                rsp_last;

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;

   // Beats waiting for the driver, and write beats the filter still owes us.
   state_cmd_type  pending_cmds[$];
   write_beat_type writes_due[$];

   // Mirror of the filter: shadow table, undo journal, fill per layer and the
   // index of the open layer (-1 while no layer is open).
   logic [VAL_W-1:0] shadow_mirror [NUM_STATES] = '{default: '0};
   log_entry_type    journal_mirror [STACK_DEPTH][LAYER_CAPACITY];
   int unsigned      layer_count [STACK_DEPTH] = '{default: 0};
   int               top_layer = -1;

   // Stack depth as seen by the stimulus generator. Push and pop change the
   // depth regardless of data, so this tracks the filter exactly.
   int gen_depth = 0;
   int queued_total = 0;

   state_filter_with_undo_stack_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_state_index (req_state_index),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_write_index (rsp_write_index),
      .rsp_write_value (rsp_write_value),
      .rsp_last        (rsp_last)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Random idle decision shared by both sides; quiet inside the calm window.
   function automatic bit idle_roll();
      if (cycle_count >= CALM_FROM && cycle_count <= CALM_TO) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < IDLE_PERCENT;
   endfunction

   function automatic void expect_write(logic [STATUS_W-1:0] status,
                                        logic [IDX_W-1:0] index,
                                        logic [VAL_W-1:0] value, logic last);
      writes_due.push_back('{status: status, index: index, value: value, last: last});
   endfunction

   // Works out the write beats that one accepted request beat causes and
   // advances the mirror exactly as the filter must.
   function automatic void apply_command(logic [OP_W-1:0] op, logic [IDX_W-1:0] index,
                                         logic [VAL_W-1:0] value);
      int unsigned   fill;
      log_entry_type undone;
      case (op)
         OP_SET: begin
            // A set that matches the shadow table is silently dropped.
            if (shadow_mirror[index] == value) begin
               return;
            end
            if (top_layer < 0) begin
               expect_write(STS_NO_LAYER, '0, '0, 1'b1);
            end else if (layer_count[top_layer] >= LAYER_CAPACITY) begin
               expect_write(STS_FULL, '0, '0, 1'b1);
            end else begin
               fill = layer_count[top_layer];
               journal_mirror[top_layer][fill] = '{index: index, value: shadow_mirror[index]};
               layer_count[top_layer] = fill + 1;
               shadow_mirror[index] = value;
               expect_write(STS_OK, index, value, 1'b1);
            end
         end
         OP_PUSH: begin
            if (top_layer + 1 >= STACK_DEPTH) begin
               expect_write(STS_OVERFLOW, '0, '0, 1'b1);
            end else begin
               top_layer++;
               layer_count[top_layer] = 0;
            end
         end
         OP_POP: begin
            if (top_layer < 0) begin
               expect_write(STS_UNDERFLOW, '0, '0, 1'b1);
            end else begin
               // Replay newest first; the oldest entry carries last. An empty
               // layer simply closes with no beat at all.
               for (fill = layer_count[top_layer]; fill > 0; fill--) begin
                  undone = journal_mirror[top_layer][fill - 1];
                  shadow_mirror[undone.index] = undone.value;
                  expect_write(STS_OK, undone.index, undone.value, fill == 1);
               end
               layer_count[top_layer] = 0;
               top_layer--;
            end
         end
         default: begin
            // Force write: stored and forwarded, never filtered or logged.
            shadow_mirror[index] = value;
            expect_write(STS_OK, index, value, 1'b1);
         end
      endcase
   endfunction

   function automatic void check_write(logic [STATUS_W-1:0] status,
                                       logic [IDX_W-1:0] index,
                                       logic [VAL_W-1:0] value, logic last);
      write_beat_type want;
      if (writes_due.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("unexpected write beat: status %0d index %0d value %h last %0b",
                     status, index, value, last);
         end
         return;
      end
      want = writes_due.pop_front();
      if (status !== want.status || index !== want.index ||
          value !== want.value || last !== want.last) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("write beat mismatch: expected status %0d index %0d value %h last %0b",
                     want.status, want.index, want.value, want.last);
            $display("                     actual   status %0d index %0d value %h last %0b",
                     status, index, value, last);
         end
      end
   endfunction

   // Request driver. A new beat is only loaded once the previous one has been
   // taken, so the payload holds steady while the filter stalls.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_cmds.size() != 0 && !idle_roll()) begin
            req_valid       <= 1'b1;
            req_opcode      <= pending_cmds[0].op;
            req_state_index <= pending_cmds[0].index;
            req_new_value   <= pending_cmds[0].value;
            pending_cmds.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= idle_roll();
      end
   end

   // Monitor. Both channels are sampled at the edge, so the values seen are
   // the ones the filter acted on. A response can never belong to a request
   // taken at the same edge, so checking first is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_write(rsp_status, rsp_write_index, rsp_write_value, rsp_last);
         end
         if (req_valid && !req_stall) begin
            apply_command(req_opcode, req_state_index, req_new_value);
         end
      end
   end

   task automatic queue_cmd(logic [OP_W-1:0] op, logic [IDX_W-1:0] index,
                            logic [VAL_W-1:0] value);
      pending_cmds.push_back('{op: op, index: index, value: value});
      queued_total++;
      if (op == OP_PUSH && gen_depth < STACK_DEPTH) begin
         gen_depth++;
      end else if (op == OP_POP && gen_depth > 0) begin
         gen_depth--;
      end
   endtask

   // Values lean toward a small pool so that redundant sets happen often.
   function automatic logic [VAL_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 2) begin
         return '0;
      end else if (r < 3) begin
         return '1;
      end else if (r < 5) begin
         return VAL_W'($urandom_range(1, 3));
      end
      return $urandom;
   endfunction

   function automatic logic [IDX_W-1:0] pick_index();
      if ($urandom_range(0, 9) < 6) begin
         return IDX_W'($urandom_range(0, 7));
      end
      return IDX_W'($urandom_range(0, NUM_STATES - 1));
   endfunction

   // Enough distinct sets to fill the open layer and run into the full case,
   // followed in about half the bursts by a pop that replays the whole layer.
   task automatic queue_burst();
      int n;
      n = LAYER_CAPACITY + $urandom_range(1, 6);
      repeat (n) begin
         queue_cmd(OP_SET, IDX_W'($urandom_range(0, NUM_STATES - 1)), $urandom);
      end
      if ($urandom_range(0, 1) == 1) begin
         queue_cmd(OP_POP, IDX_W'($urandom), $urandom);
      end
   endtask

   // Mostly well-formed layer traffic: pushes, sets inside layers, pops.
   // Sets with no layer open, overflow and underflow show up as noise.
   task automatic queue_random(int target);
      int unsigned r;
      while (queued_total < target) begin
         r = $urandom_range(0, 99);
         if (gen_depth == 0 && r < 60) begin
            queue_cmd(OP_PUSH, IDX_W'($urandom), $urandom);
         end else if (gen_depth > 0 && r < 3) begin
            queue_burst();
         end else if (r < 18) begin
            queue_cmd(OP_PUSH, IDX_W'($urandom), $urandom);
         end else if (r < 32) begin
            queue_cmd(OP_POP, IDX_W'($urandom), $urandom);
         end else if (r < 42) begin
            queue_cmd(OP_FORCE, pick_index(), pick_value());
         end else begin
            queue_cmd(OP_SET, pick_index(), pick_value());
         end
      end
   endtask

   // Waits, on falling edges, until every beat is taken and every write is back.
   task automatic wait_quiet();
      while (pending_cmds.size() != 0 || req_valid || writes_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // The queue is only touched on falling edges, away from the driver.
      @(negedge clock);

      // Directed opening. With no layer open a changing set is refused, a
      // matching one is dropped and a pop underflows.
      queue_cmd(OP_SET, 8'd5, 32'd1);
      queue_cmd(OP_SET, 8'd5, 32'd0);
      queue_cmd(OP_POP, 8'd0, 32'd0);
      // Force writes at both ends of the table and the value range.
      queue_cmd(OP_FORCE, 8'd0, 32'hFFFF_FFFF);
      queue_cmd(OP_FORCE, 8'd255, 32'h0000_0000);
      // A layer opened and closed with nothing logged gives no beat.
      queue_cmd(OP_PUSH, 8'd0, 32'd0);
      queue_cmd(OP_POP, 8'd0, 32'd0);
      // Logged sets, one of them redundant, with alternating bit patterns.
      queue_cmd(OP_PUSH, 8'hFF, 32'hFFFF_FFFF);
      queue_cmd(OP_SET, 8'd255, 32'hFFFF_FFFF);
      queue_cmd(OP_SET, 8'd255, 32'hFFFF_FFFF);
      queue_cmd(OP_SET, 8'd0, 32'h0000_0000);
      queue_cmd(OP_SET, 8'd170, 32'hAAAA_AAAA);
      queue_cmd(OP_SET, 8'd85, 32'h5555_5555);
      // Fill the stack, then one push too many.
      repeat (STACK_DEPTH - 1) queue_cmd(OP_PUSH, 8'd0, 32'd0);
      queue_cmd(OP_PUSH, 8'd0, 32'd0);
      // One logged set in the top layer, then unwind it and the first layer's
      // four entries further down when the stack returns there.
      queue_cmd(OP_SET, 8'd1, 32'd7);
      queue_cmd(OP_POP, 8'd0, 32'd0);
      queue_cmd(OP_POP, 8'd0, 32'd0);

      // Random body, starting with a full-layer burst.
      queue_burst();
      queue_random(HALF_ITEMS);

      // The sender holds back until the filter has nothing left to deliver.
      wait_quiet();
      repeat (SETTLE_CYCLES) @(negedge clock);

      queue_random(TOTAL_ITEMS);

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      error_count += writes_due.size();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
